// ----- rtl/epra_pkg.sv -----
package epra_pkg;

  localparam int unsigned TicksW = 32;
  localparam int unsigned LimitW = 20;
  localparam int unsigned BatchW = 8;
  localparam int unsigned CmW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  localparam logic [LimitW-1:0] MinTicksRst = 20'd4640;
  localparam logic [LimitW-1:0] MaxTicksRst = 20'd932960;
  localparam logic [BatchW-1:0] BatchRst    = 8'd100;

  // cm = floor((t*343 + 800000) / 1600000), t < 2^20.
  // Done as (t*ceil(343*2^41/1600000) + 2^40) >> 41; overshoot stays under
  // one step of the exact fraction over the whole 20-bit range.
  localparam int unsigned   CmShift = 41;
  localparam int unsigned   ProdW   = 49;
  localparam logic [28:0]   CmRecip = 29'd471415611;
  localparam logic [ProdW-1:0] CmBias = ProdW'(1) << (CmShift - 1);

  typedef enum logic [1:0] {
    ST_IN_RANGE = 2'd0,
    ST_TOO_NEAR = 2'd1,
    ST_TOO_FAR  = 2'd2
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_TICKS = 2'd0,
    REG_MAX_TICKS = 2'd1,
    REG_BATCH     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [LimitW-1:0] min_echo_ticks;
    logic [LimitW-1:0] max_echo_ticks;
    logic [BatchW-1:0] samples_per_batch;
  } cfg_t;

  typedef struct packed {
    status_t        sample_status;
    logic [CmW-1:0] sample_cm;
    logic           batch_done;
    logic [CmW-1:0] average_cm;
  } res_t;

  function automatic logic [CmW-1:0] ticks_to_cm(input logic [LimitW-1:0] t);
    logic [ProdW-1:0] p;
    p = ProdW'(t) * ProdW'(CmRecip) + CmBias;
    return p[CmShift +: CmW];
  endfunction

endpackage

// ----- rtl/epra_in_if.sv -----
interface epra_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] echo_start_ticks;
  logic [31:0] echo_end_ticks;

  modport source (output valid, output echo_start_ticks, output echo_end_ticks,
                  input ready);
  modport sink   (input valid, input echo_start_ticks, input echo_end_ticks,
                  output ready);
endinterface

// ----- rtl/epra_out_if.sv -----
interface epra_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] sample_status;
  logic [7:0] sample_cm;
  logic       batch_done;
  logic [7:0] average_cm;

  modport source (output valid, output sample_status, output sample_cm,
                  output batch_done, output average_cm, input ready);
  modport sink   (input valid, input sample_status, input sample_cm,
                  input batch_done, input average_cm, output ready);
endinterface

// ----- rtl/echo_pulse_ranging_averager.sv -----
// Echo pulse ranging averager.
// in_ch  : valid/ready channel, one transaction per echo: rising- and
//          falling-edge captures of an 80 MHz free-running timer.
// out_ch : valid/ready channel, exactly one transaction per input: status
//          (in range / too near / too far), distance in cm, batch flag and
//          the running halving average (final when batch_done is set).
// cfg_*  : write-only register port (min ticks, max ticks, batch size);
//          write only while no transaction is in flight.
// Pipeline: input register, then result register. Throughput: one
//          transaction per cycle while the receiver takes each result;
//          the input register and the result register each advance as soon
//          as the stage ahead is free or being emptied.
// Per sample: one 20x29 constant multiply for the cm conversion plus a
//          couple of 32-bit compares, all in the cycle between the two
//          registers.
// Reset (rst_n low, synchronous): both stages empty, average and sample
//          counter cleared, registers back to their defaults.
// Receiver stall: the result holds on out_ch; one more transaction is taken
//          into the input register, then in_ch.ready drops.
module echo_pulse_ranging_averager (
  input  logic                          clk,
  input  logic                          rst_n,
  epra_in_if.sink                       in_ch,
  epra_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [epra_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [epra_pkg::CfgDataW-1:0] cfg_data
);

  epra_pkg::cfg_t cfg;
  epra_pkg::res_t res;

  // input register
  logic                        s1_valid_r;
  logic [epra_pkg::TicksW-1:0] s1_start_r, s1_end_r;
  // result register
  logic                        out_valid_r;
  epra_pkg::res_t              out_r;

  logic out_free, s1_move, in_take;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || out_free;

  epra_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_wr_en),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // state (average, counter) commits when the sample enters the result reg
  epra_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .start_ticks (s1_start_r),
    .end_ticks   (s1_end_r),
    .commit      (s1_move),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_start_r <= in_ch.echo_start_ticks;
      s1_end_r   <= in_ch.echo_end_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample_status = out_r.sample_status;
  assign out_ch.sample_cm     = out_r.sample_cm;
  assign out_ch.batch_done    = out_r.batch_done;
  assign out_ch.average_cm    = out_r.average_cm;

  // full pipe with a stalled receiver must push back on the sender
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while both stages are blocked");

  // distance only reported for in-range samples
  a_cm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.sample_status != epra_pkg::ST_IN_RANGE)
      |-> (out_r.sample_cm == '0))
    else $error("nonzero distance on out-of-range sample");

  // an accepted sample is in the input register on the next edge
  // unless the input register is full and the result register is held
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && !(s1_valid_r && !out_free)) |=> s1_valid_r)
    else $error("input register lost a transaction");

  // reset empties the result stage
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid straight after reset");

endmodule

// ----- rtl/epra_cfg.sv -----
module epra_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [epra_pkg::CfgIdxW-1:0]  wr_idx,
  input  logic [epra_pkg::CfgDataW-1:0] wr_data,
  output epra_pkg::cfg_t                cfg
);

  epra_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_echo_ticks    <= epra_pkg::MinTicksRst;
      cfg_r.max_echo_ticks    <= epra_pkg::MaxTicksRst;
      cfg_r.samples_per_batch <= epra_pkg::BatchRst;
    end else if (wr_en) begin
      unique case (wr_idx)
        epra_pkg::REG_MIN_TICKS: cfg_r.min_echo_ticks <= wr_data;
        epra_pkg::REG_MAX_TICKS: cfg_r.max_echo_ticks <= wr_data;
        epra_pkg::REG_BATCH:
          cfg_r.samples_per_batch <= wr_data[epra_pkg::BatchW-1:0];
        default: ; // unmapped index: dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/epra_core.sv -----
module epra_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  epra_pkg::cfg_t               cfg,
  input  logic [epra_pkg::TicksW-1:0]  start_ticks,
  input  logic [epra_pkg::TicksW-1:0]  end_ticks,
  input  logic                         commit,
  output epra_pkg::res_t               res
);

  logic [epra_pkg::CmW-1:0]    avg_r, avg_nxt, avg_upd;
  logic [epra_pkg::BatchW-1:0] cnt_r, cnt_nxt;
  logic [epra_pkg::TicksW-1:0] ticks;
  logic                        too_near, too_far;
  logic [epra_pkg::CmW-1:0]    cm;
  logic [epra_pkg::CmW:0]      avg_sum;
  logic [epra_pkg::BatchW:0]   count;
  logic                        done;
  epra_pkg::status_t           status;

  always_comb begin
    ticks    = end_ticks - start_ticks;
    too_near = ticks < epra_pkg::TicksW'(cfg.min_echo_ticks);
    too_far  = ticks > epra_pkg::TicksW'(cfg.max_echo_ticks);

    // too-near wins when the limits cross
    priority if (too_near) begin
      status = epra_pkg::ST_TOO_NEAR;
    end else if (too_far) begin
      status = epra_pkg::ST_TOO_FAR;
    end else begin
      status = epra_pkg::ST_IN_RANGE;
    end

    // in range implies ticks fits the 20-bit limit
    cm = (status == epra_pkg::ST_IN_RANGE)
         ? epra_pkg::ticks_to_cm(ticks[epra_pkg::LimitW-1:0]) : '0;

    avg_sum = {1'b0, avg_r} + {1'b0, cm};
    avg_upd = (cm != '0) ? avg_sum[epra_pkg::CmW:1] : avg_r;

    count = {1'b0, cnt_r} + 1'b1;
    done  = count >= {1'b0, cfg.samples_per_batch};

    if (done) begin
      avg_nxt = '0;
      cnt_nxt = '0;
    end else begin
      avg_nxt = avg_upd;
      cnt_nxt = count[epra_pkg::BatchW-1:0];
    end

    res.sample_status = status;
    res.sample_cm     = cm;
    res.batch_done    = done;
    res.average_cm    = avg_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
      cnt_r <= '0;
    end else if (commit) begin
      avg_r <= avg_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
